@@ rtl/ale_pkg.sv @@
// shared types and constants for the array list engine
`default_nettype none

package ale_pkg;

	localparam int DEPTH  = 128;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OP_W   = 3;
	localparam int POS_W  = 8;
	localparam int STS_W  = 2;
	// wide enough to compare a position against count + 1 without wrap
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 3'd0,
		OP_INSERT   = 3'd1,
		OP_DELETE   = 3'd2,
		OP_LOCATE   = 3'd3,
		OP_RETRIEVE = 3'd4
	} op_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_INSERT,
		ACT_DELETE,
		ACT_LOCATE,
		ACT_RETRIEVE
	} act_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP,
		S_INS,
		S_DN,
		S_SCAN,
		S_GET,
		S_GRAB,
		S_RESP
	} ale_state_t;

	typedef struct packed {
		logic load;
		logic clr;
		logic run_up;
		logic run_dn;
		logic run_scan;
		logic run_get;
		logic grab;
		logic ins_wr;
		logic dn_done;
		logic scan_miss;
	} ale_cmd_t;

	typedef struct packed {
		act_t act;
		logic issue;
		logic pend;
		logic hit;
	} ale_sts_t;

endpackage

`default_nettype wire

@@ rtl/ale_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
`default_nettype none

module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/ale_ctrl.sv @@
// operation sequencer for the array list engine
`default_nettype none

module ale_ctrl import ale_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire ale_sts_t sts,
	output ale_cmd_t      cmd,
	output logic          busy,
	output logic          done
);

	ale_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (sts.act)
						ACT_INSERT:   state_d = S_UP;
						ACT_DELETE:   state_d = S_DN;
						ACT_LOCATE:   state_d = S_SCAN;
						ACT_RETRIEVE: state_d = S_GET;
						default:      state_d = S_RESP;
					endcase
				end
			end
			S_UP: begin
				if (!sts.issue) begin
					state_d = S_INS;
				end
			end
			S_INS:  state_d = S_RESP;
			S_DN: begin
				if (!sts.issue) begin
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				if (sts.hit || (!sts.issue && !sts.pend)) begin
					state_d = S_RESP;
				end
			end
			S_GET:  state_d = S_GRAB;
			S_GRAB: state_d = S_RESP;
			S_RESP: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
				cmd.clr  = start && (sts.act == ACT_CLEAR);
			end
			S_UP:   cmd.run_up = 1'b1;
			S_INS:  cmd.ins_wr = 1'b1;
			S_DN: begin
				cmd.run_dn  = 1'b1;
				cmd.dn_done = !sts.issue;
			end
			S_SCAN: begin
				cmd.run_scan  = 1'b1;
				cmd.scan_miss = !sts.hit && !sts.issue && !sts.pend;
			end
			S_GET:  cmd.run_get = 1'b1;
			S_GRAB: cmd.grab = 1'b1;
			S_RESP: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/ale_dp.sv @@
// list store, count, walk pointer and result registers
`default_nettype none

module ale_dp import ale_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ale_cmd_t                 cmd,
	input  wire logic [OP_W-1:0]          op,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic [POS_W-1:0]         position,
	output ale_sts_t                      sts,
	output logic [STS_W-1:0]              status,
	output logic [POS_W-1:0]              found_position,
	output logic signed [DATA_W-1:0]      read_value,
	output logic [POS_W-1:0]              entry_count,
	output logic                          is_empty
);

	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         q_q;
	logic [CNT_W-1:0]         pc_q;
	logic [DATA_W-1:0]        val_q;
	logic [STS_W-1:0]         status_q;
	logic [POS_W-1:0]         found_q;
	logic [DATA_W-1:0]        rd_q;
	logic                     pend_s1;
	logic [CNT_W-1:0]         tag_s1;

	act_t                     act;
	status_t                  st;
	logic [CMP_W-1:0]         pos_x;
	logic [CMP_W-1:0]         cnt_x;
	logic [CNT_W-1:0]         pos_c;
	logic                     run;
	logic                     issue;
	logic [CNT_W-1:0]         rq;
	logic                     re;
	logic                     we;
	logic [ADDR_W-1:0]        waddr;
	logic [DATA_W-1:0]        wdata;
	logic [DATA_W-1:0]        rdata;

	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(cnt_q);
	assign pos_c = CNT_W'(position);

	// decode the offered operation against the current count
	always_comb begin
		act = ACT_NONE;
		st  = ST_OK;
		unique case (op) inside
			OP_CLEAR: act = ACT_CLEAR;
			OP_INSERT: begin
				if (cnt_q == CNT_W'(DEPTH)) begin
					st = ST_FULL;
				end else if (position == '0 || pos_x > cnt_x + CMP_W'(1)) begin
					st = ST_RANGE;
				end else begin
					act = ACT_INSERT;
				end
			end
			OP_DELETE, OP_RETRIEVE: begin
				if (cnt_q == '0) begin
					st = ST_EMPTY;
				end else if (position == '0 || pos_x > cnt_x) begin
					st = ST_RANGE;
				end else begin
					act = (op == OP_DELETE) ? ACT_DELETE : ACT_RETRIEVE;
				end
			end
			OP_LOCATE: act = ACT_LOCATE;
			default: act = ACT_NONE;
		endcase
	end

	assign run   = cmd.run_up || cmd.run_dn || cmd.run_scan;
	// shifting up walks from the top down to the insert position
	assign issue = cmd.run_up ? (q_q >= pc_q) : (q_q < cnt_q);
	assign rq    = cmd.run_up ? (q_q - CNT_W'(1)) : q_q;
	assign re    = (run && issue) || cmd.run_get;

	assign we    = (pend_s1 && (cmd.run_up || cmd.run_dn)) || cmd.ins_wr;
	assign waddr = cmd.ins_wr ? ADDR_W'(pc_q - CNT_W'(1)) : ADDR_W'(tag_s1);
	assign wdata = cmd.ins_wr ? val_q : rdata;

	ale_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(rq[ADDR_W-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= run && issue;
			if (cmd.clr) begin
				cnt_q <= '0;
			end else if (cmd.ins_wr) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.dn_done) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= cmd.run_dn ? (q_q - CNT_W'(1)) : q_q;
		if (cmd.load) begin
			val_q    <= value;
			pc_q     <= pos_c;
			status_q <= st;
			found_q  <= '0;
			rd_q     <= '0;
			unique case (act)
				ACT_INSERT:   q_q <= cnt_q;
				ACT_DELETE:   q_q <= pos_c;
				ACT_RETRIEVE: q_q <= pos_c - CNT_W'(1);
				default:      q_q <= '0;
			endcase
		end else begin
			if (cmd.run_up) begin
				q_q <= q_q - CNT_W'(1);
			end else if (run) begin
				q_q <= q_q + CNT_W'(1);
			end
			if (cmd.run_scan && sts.hit) begin
				found_q <= POS_W'({1'b0, tag_s1} + (CNT_W + 1)'(1));
			end else if (cmd.scan_miss) begin
				found_q <= POS_W'({1'b0, cnt_q} + (CNT_W + 1)'(1));
			end
			if (cmd.grab) begin
				rd_q <= rdata;
			end
		end
	end

	assign sts.act   = act;
	assign sts.issue = issue;
	assign sts.pend  = pend_s1;
	assign sts.hit   = pend_s1 && (rdata == val_q);

	assign status         = status_q;
	assign found_position = found_q;
	assign read_value     = $signed(rd_q);
	assign entry_count    = POS_W'(cnt_q);
	assign is_empty       = (cnt_q == '0);

endmodule

`default_nettype wire

@@ rtl/array_list_engine_core.sv @@
// top level of the array list engine: sequencer plus list datapath
//
//  channel   | transfer when        | fields
//  ----------+----------------------+----------------------------------------------------
//  command   | start && !busy       | op, value, position
//  result    | done (one cycle)     | status, found_position, read_value, entry_count,
//            |                      | is_empty
//
// one operation at a time; the store has one write and one read port and moves one entry
// a cycle. clear and rejected ops go straight to the result; retrieve reads the entry;
// delete shifts later entries down; insert shifts entries up, then writes the value;
// locate scans to the first hit or the end. busy drops the cycle after the strobe. reset
// empties the list at once; store contents stay undefined. the result cannot be held off.
`default_nettype none

module array_list_engine_core import ale_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [OP_W-1:0]          op,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic [POS_W-1:0]         position,
	output logic                          done,
	output logic [STS_W-1:0]              status,
	output logic [POS_W-1:0]              found_position,
	output logic signed [DATA_W-1:0]      read_value,
	output logic [POS_W-1:0]              entry_count,
	output logic                          is_empty
);

	ale_cmd_t cmd;
	ale_sts_t sts;

	ale_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	ale_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.op            (op),
		.value         (value),
		.position      (position),
		.sts           (sts),
		.status        (status),
		.found_position(found_position),
		.read_value    (read_value),
		.entry_count   (entry_count),
		.is_empty      (is_empty)
	);

endmodule

`default_nettype wire

@@ rtl/ale_chk.sv @@
// port-level checks for the array list engine, bound to the top level
`default_nettype none

module ale_chk import ale_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic                     done,
	input wire logic [STS_W-1:0]         status,
	input wire logic signed [DATA_W-1:0] read_value,
	input wire logic [POS_W-1:0]         entry_count,
	input wire logic                     is_empty
);

	// an accepted command leaves the engine busy in the following cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("engine not busy after a command transfer");

	// a result is always followed by readiness
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("engine still busy after a result");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (entry_count == '0)))
		else $error("empty flag disagrees with entry count");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_value == '0))
		else $error("read value not zero on a failed operation");

endmodule

bind array_list_engine_core ale_chk u_ale_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.read_value (read_value),
	.entry_count(entry_count),
	.is_empty   (is_empty)
);

`default_nettype wire

@@ verif/array_list_engine_checker.sv @@
// checker for the array list engine: keeps its own copy of the list and compares every result
module array_list_engine_checker
	import ale_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic                     busy,
	input  wire logic [OP_W-1:0]          op,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic [POS_W-1:0]         position,
	input  wire logic                     done,
	input  wire logic [STS_W-1:0]         status,
	input  wire logic [POS_W-1:0]         found_position,
	input  wire logic signed [DATA_W-1:0] read_value,
	input  wire logic [POS_W-1:0]         entry_count,
	input  wire logic                     is_empty,
	output int                            fail_count,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [POS_W-1:0]  found_position;
		logic [DATA_W-1:0] read_value;
		logic [POS_W-1:0]  entry_count;
		logic              is_empty;
	} list_result_t;

	logic [DATA_W-1:0] list_words [DEPTH];
	int unsigned       list_len = 0;
	list_result_t      expected_results [$];

	// applies one command to the shadow list and returns what the block should report
	function automatic list_result_t apply_list_op(logic [OP_W-1:0] code,
			logic [DATA_W-1:0] key, logic [POS_W-1:0] pos);
		list_result_t r;
		int unsigned  q;
		int unsigned  p;
		r = '0;
		p = pos;
		case (code)
			OP_CLEAR: begin
				list_len = 0;
			end
			OP_INSERT: begin
				if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else if (p < 1 || p > list_len + 1) begin
					r.status = ST_RANGE;
				end else begin
					for (q = list_len; q >= p; q--)
						list_words[q] = list_words[q-1];
					list_words[p-1] = key;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (p < 1 || p > list_len) begin
					r.status = ST_RANGE;
				end else begin
					for (q = p; q < list_len; q++)
						list_words[q-1] = list_words[q];
					list_len--;
				end
			end
			OP_LOCATE: begin
				// first hit wins; a miss reports one past the end
				q = 1;
				while (q <= list_len && list_words[q-1] != key)
					q++;
				r.found_position = POS_W'(q);
			end
			OP_RETRIEVE: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else if (p < 1 || p > list_len)
					r.status = ST_RANGE;
				else
					r.read_value = list_words[p-1];
			end
			default: begin
			end
		endcase
		r.entry_count = POS_W'(list_len);
		r.is_empty    = (list_len == 0);
		return r;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%h, got 0x%h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		list_result_t want;
		if (!arst_n) begin
			list_len = 0;
			expected_results.delete();
		end else begin
			// results first: a command is never accepted on the edge of its own result
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result strobe with no command outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", DATA_W'(want.status), DATA_W'(status));
					check_field("found_position", DATA_W'(want.found_position),
						DATA_W'(found_position));
					check_field("read_value", want.read_value, read_value);
					check_field("entry_count", DATA_W'(want.entry_count),
						DATA_W'(entry_count));
					check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(is_empty));
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_list_op(op, value, position));
		end
		outstanding = expected_results.size();
	end

endmodule

@@ verif/array_list_engine_core_tb.sv @@
// testbench top for the array list engine: drives commands and reports the verdict
module array_list_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ale_pkg::*;

	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT  = 400000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;
	logic                     done;
	logic [STS_W-1:0]         status;
	logic [POS_W-1:0]         found_position;
	logic signed [DATA_W-1:0] read_value;
	logic [POS_W-1:0]         entry_count;
	logic                     is_empty;

	int fail_count;
	int outstanding;
	int cycles = 0;

	logic [POS_W-1:0]  last_count = '0;
	int                peak_count = 0;
	int                cmd_tally [8];
	int                status_tally [4];
	logic [DATA_W-1:0] key_pool [8];

	array_list_engine_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.value          (value),
		.position       (position),
		.done           (done),
		.status         (status),
		.found_position (found_position),
		.read_value     (read_value),
		.entry_count    (entry_count),
		.is_empty       (is_empty)
	);

	array_list_engine_checker list_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.op             (op),
		.value          (value),
		.position       (position),
		.done           (done),
		.status         (status),
		.found_position (found_position),
		.read_value     (read_value),
		.entry_count    (entry_count),
		.is_empty       (is_empty),
		.fail_count     (fail_count),
		.outstanding    (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("array_list_engine_core: mismatch");
			$finish;
		end
	end

	// length after the latest result, used to aim positions
	always @(posedge clk) begin
		if (done) begin
			last_count <= entry_count;
			if (int'(entry_count) > peak_count)
				peak_count = int'(entry_count);
			status_tally[status]++;
		end
	end

	// waits until the block can take a command, then idles for the requested gap
	task automatic wait_ready(int gap);
		while (busy)
			@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// busy is low here, so the transfer happens on the coming rising edge
	task automatic drive(logic [OP_W-1:0] code, logic [DATA_W-1:0] key,
			logic [POS_W-1:0] pos);
		op       <= code;
		value    <= key;
		position <= pos;
		start    <= 1'b1;
		cmd_tally[code]++;
		@(negedge clk);
	endtask

	task automatic send(logic [OP_W-1:0] code, logic [DATA_W-1:0] key,
			logic [POS_W-1:0] pos);
		wait_ready(($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0);
		drive(code, key, pos);
	endtask

	initial begin
		int                n;
		int                gap;
		int                roll;
		int                ins_pct;
		int                del_pct;
		int                clr_pct;
		logic [OP_W-1:0]   code;
		logic [DATA_W-1:0] key;
		logic [POS_W-1:0]  pos;

		arst_n   <= 1'b0;
		start    <= 1'b0;
		op       <= OP_CLEAR;
		value    <= '0;
		position <= '0;
		foreach (key_pool[k])
			key_pool[k] = $urandom;
		key_pool[0] = 32'h7fff_ffff;
		key_pool[1] = 32'h8000_0000;
		key_pool[2] = 32'h0000_0000;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list corner cases
		send(OP_LOCATE, 32'd5, 8'd1);
		send(OP_DELETE, $urandom, 8'd1);
		send(OP_RETRIEVE, $urandom, 8'd1);
		send(OP_INSERT, $urandom, 8'd0);
		send(OP_INSERT, $urandom, 8'd2);
		// build 0, -1, min, max through front, end and middle inserts
		send(OP_INSERT, 32'h8000_0000, 8'd1);
		send(OP_INSERT, 32'h7fff_ffff, 8'd2);
		send(OP_INSERT, 32'h0000_0000, 8'd1);
		send(OP_INSERT, 32'hffff_ffff, 8'd2);
		send(OP_INSERT, $urandom, 8'd6);
		send(OP_LOCATE, 32'h7fff_ffff, POS_W'($urandom));
		send(OP_LOCATE, 32'hffff_ffff, POS_W'($urandom));
		send(OP_LOCATE, 32'd12345, POS_W'($urandom));
		send(OP_RETRIEVE, $urandom, 8'd0);
		send(OP_RETRIEVE, $urandom, 8'd5);
		send(OP_RETRIEVE, $urandom, 8'd255);
		send(OP_RETRIEVE, $urandom, 8'd4);
		send(OP_DELETE, $urandom, 8'd0);
		send(OP_DELETE, $urandom, 8'd255);
		send(OP_DELETE, $urandom, 8'd2);
		send(OP_DELETE, $urandom, 8'd3);
		send(3'd5, $urandom, POS_W'($urandom));
		send(3'd6, $urandom, POS_W'($urandom));
		send(3'd7, $urandom, POS_W'($urandom));
		send(OP_CLEAR, $urandom, POS_W'($urandom));

		// fill to full, then churn, then drain; no idling near the end
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			gap = 0;
			if (n < RANDOM_ITEMS - 60 && $urandom_range(0, 3) == 0)
				gap = $urandom_range(1, 15);
			wait_ready(gap);
			if (n < 200) begin
				ins_pct = 88; del_pct = 4; clr_pct = 0;
			end else if (n < 320) begin
				ins_pct = 40; del_pct = 35; clr_pct = 3;
			end else begin
				ins_pct = 20; del_pct = 55; clr_pct = 3;
			end
			roll = $urandom_range(0, 99);
			if (roll < 2)
				code = OP_W'($urandom_range(5, 7));
			else if (roll < 2 + clr_pct)
				code = OP_CLEAR;
			else if (roll < 2 + clr_pct + ins_pct)
				code = OP_INSERT;
			else if (roll < 2 + clr_pct + ins_pct + del_pct)
				code = OP_DELETE;
			else
				code = ($urandom_range(0, 1) == 0) ? OP_LOCATE : OP_RETRIEVE;

			key = $urandom;
			if ((code == OP_INSERT && $urandom_range(0, 1) == 0) ||
					(code == OP_LOCATE && $urandom_range(0, 9) < 6))
				key = key_pool[$urandom_range(0, 7)];

			if ($urandom_range(0, 9) == 0)
				pos = POS_W'($urandom);
			else if (code == OP_INSERT)
				pos = POS_W'($urandom_range(1, last_count + 1));
			else if ((code == OP_DELETE || code == OP_RETRIEVE) && last_count != 0)
				pos = POS_W'($urandom_range(1, last_count));
			else
				pos = POS_W'($urandom);
			drive(code, key, pos);
		end
		start <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d clear, %0d insert, %0d delete, %0d locate, %0d retrieve, %0d unused",
			cmd_tally[OP_CLEAR], cmd_tally[OP_INSERT], cmd_tally[OP_DELETE],
			cmd_tally[OP_LOCATE], cmd_tally[OP_RETRIEVE],
			cmd_tally[5] + cmd_tally[6] + cmd_tally[7]);
		$display("results: %0d ok, %0d full, %0d empty, %0d out of range; longest list %0d",
			status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
			status_tally[ST_RANGE], peak_count);
		if (fail_count == 0 && outstanding == 0)
			$display("array_list_engine_core: match");
		else
			$display("array_list_engine_core: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ale_pkg.sv
rtl/ale_ram.sv
rtl/ale_ctrl.sv
rtl/ale_dp.sv
rtl/array_list_engine_core.sv
rtl/ale_chk.sv
verif/array_list_engine_checker.sv
verif/array_list_engine_core_tb.sv
